// ----- src/cbs_pkg.sv -----
// ----------------------------------------------------------------------------
// cbs_pkg: shared types and constants of the capability bitmap store
// Sizes of the bitmap memory, request and status codes, memory port structs.
// ----------------------------------------------------------------------------
package cbs_pkg;

	localparam int NUM_TASKS = 2048;
	localparam int WORD_BITS = 32;
	localparam int CB_WORDS  = NUM_TASKS / WORD_BITS;
	localparam int IDX_W     = 11;
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int WADDR_W   = $clog2(CB_WORDS);
	localparam int SIZE_W    = 12;
	localparam int ACT_W     = 2;
	localparam int STAT_W    = 2;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [WADDR_W-1:0]   waddr_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_INSERT = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_LOOKUP = 2'd2
	} act_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_PRESENT  = 2'd1,
		ST_NO_MEM   = 2'd2,
		ST_CONFLICT = 2'd3
	} stat_t;

	typedef struct packed {
		logic   en;
		waddr_t addr;
	} rd_req_t;

	typedef struct packed {
		logic   en;
		waddr_t addr;
		word_t  data;
	} wr_req_t;

endpackage

// ----- src/cbs_if.sv -----
// ----------------------------------------------------------------------------
// cbs_req_if / cbs_rsp_if: request and result channels
// Valid/ready handshake; a word moves at an edge with valid and ready high.
// ----------------------------------------------------------------------------
interface cbs_req_if;
	import cbs_pkg::*;
	logic               valid;
	logic               ready;
	logic [ACT_W-1:0]   action;
	logic [IDX_W-1:0]   cap_index;
	logic               full_space;
	logic               store_granted;

	modport source(output valid, action, cap_index, full_space, store_granted,
		input ready);
	modport sink(input valid, action, cap_index, full_space, store_granted,
		output ready);
endinterface

interface cbs_rsp_if;
	import cbs_pkg::*;
	logic               valid;
	logic               ready;
	logic [STAT_W-1:0]  status;
	logic               present;
	logic [IDX_W-1:0]   mapped_phys;
	logic [SIZE_W-1:0]  mapped_size;

	modport source(output valid, status, present, mapped_phys, mapped_size,
		input ready);
	modport sink(input valid, status, present, mapped_phys, mapped_size,
		output ready);
endinterface

// ----- src/cbs_bitmap_ram.sv -----
// ----------------------------------------------------------------------------
// cbs_bitmap_ram: bitmap word memory
// One write and one registered read per cycle; a row never written reads zero.
// ----------------------------------------------------------------------------
module cbs_bitmap_ram (
	input  logic             clk,
	input  logic             arst_n,
	input  cbs_pkg::rd_req_t rd,
	input  cbs_pkg::wr_req_t wr,
	output cbs_pkg::word_t   rdata
);
	import cbs_pkg::*;

	word_t               mem [CB_WORDS];
	logic [CB_WORDS-1:0] row_valid_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (wr.en) begin
			row_valid_q[wr.addr] <= 1'b1;
		end
	end

	// read-before-write: the caller forwards a same-row write
	always_ff @(posedge clk) begin
		if (rd.en) begin
			rdata <= row_valid_q[rd.addr] ? mem[rd.addr] : '0;
		end
	end

endmodule

// ----- src/cbs_core.sv -----
// ----------------------------------------------------------------------------
// cbs_core: request pipeline of the capability bitmap store
// Issues the row read, then modifies and writes back the row with forwarding.
// ----------------------------------------------------------------------------
module cbs_core (
	input  logic              clk,
	input  logic              arst_n,
	cbs_req_if.sink           req,
	cbs_rsp_if.source         rsp,
	output cbs_pkg::rd_req_t  rd,
	output cbs_pkg::wr_req_t  wr,
	input  cbs_pkg::word_t    rdata
);
	import cbs_pkg::*;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [IDX_W-1:0] cap_index;
		logic             full_space;
		logic             store_granted;
	} item_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic              present;
		logic [IDX_W-1:0]  mapped_phys;
		logic [SIZE_W-1:0] mapped_size;
	} res_t;

	logic  v_s1;
	item_t item_s1;
	logic  byp_s1;
	word_t byp_data_s1;

	logic  exists_q;
	logic  grant_q;
	logic  rsp_valid_q;
	res_t  res_q;

	logic  adv, commit, take;
	word_t row, mask, new_row;
	logic  hit, do_wr, set_exists, set_grant;
	res_t  res;

	assign adv       = !rsp_valid_q || rsp.ready;
	assign commit    = v_s1 && adv;
	assign req.ready = !v_s1 || adv;
	assign take      = req.valid && req.ready;

	assign rd.en   = take;
	assign rd.addr = req.cap_index[IDX_W-1:BIT_W];

	assign row  = byp_s1 ? byp_data_s1 : rdata;
	assign mask = word_t'(1) << item_s1.cap_index[BIT_W-1:0];
	assign hit  = |(row & mask);

	always_comb begin
		res        = '0;
		new_row    = row;
		do_wr      = 1'b0;
		set_exists = 1'b0;
		set_grant  = 1'b0;
		unique case (item_s1.action)
			ACT_INSERT: begin
				if (item_s1.full_space && item_s1.cap_index == '0) begin
					if (exists_q) begin
						res.status = ST_CONFLICT;
					end else if (grant_q) begin
						res.status = ST_PRESENT;
					end else begin
						set_grant = 1'b1;
					end
				end else if (!exists_q && !item_s1.store_granted) begin
					res.status = ST_NO_MEM;
				end else begin
					// rows are all zero until the bitmap exists
					set_exists = 1'b1;
					res.status = hit ? ST_PRESENT : ST_OK;
					new_row    = row | mask;
					do_wr      = 1'b1;
				end
			end
			ACT_DELETE: begin
				if (exists_q) begin
					res.present = hit;
					new_row     = row & ~mask;
					do_wr       = 1'b1;
				end
			end
			ACT_LOOKUP: begin
				if (exists_q) begin
					res.mapped_phys = item_s1.cap_index;
					res.mapped_size = SIZE_W'(1);
					res.present     = grant_q || hit;
				end else begin
					res.mapped_size = SIZE_W'(NUM_TASKS);
					res.present     = grant_q;
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

	assign wr.en   = commit && do_wr;
	assign wr.addr = item_s1.cap_index[IDX_W-1:BIT_W];
	assign wr.data = new_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			exists_q    <= 1'b0;
			grant_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (take) begin
				v_s1 <= 1'b1;
			end else if (commit) begin
				v_s1 <= 1'b0;
			end
			if (commit) begin
				rsp_valid_q <= 1'b1;
				if (set_exists) begin
					exists_q <= 1'b1;
				end
				if (set_grant) begin
					grant_q <= 1'b1;
				end
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.action        <= req.action;
			item_s1.cap_index     <= req.cap_index;
			item_s1.full_space    <= req.full_space;
			item_s1.store_granted <= req.store_granted;
			// forward a write to the row being read in the same cycle
			byp_s1      <= wr.en && (wr.addr == rd.addr);
			byp_data_s1 <= wr.data;
		end
		if (commit) begin
			res_q <= res;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = res_q.status;
	assign rsp.present     = res_q.present;
	assign rsp.mapped_phys = res_q.mapped_phys;
	assign rsp.mapped_size = res_q.mapped_size;

endmodule

// ----- src/capability_bitmap_space.sv -----
// ----------------------------------------------------------------------------
// capability_bitmap_space: per-space capability store
// Bitmap of task capabilities in a 64 x 32 memory plus existence and
// whole-space grant flags; insert, delete and lookup, one result per request.
//
//   channel  dir  word fields
//   req      in   action, cap_index, full_space, store_granted
//   rsp      out  status, present, mapped_phys, mapped_size
//
// One request per cycle while rsp is taken; the row is read at the edge that
// takes the request, then modified and written back while the result enters
// the output register, as soon as that register is empty or its word is taken.
// Same-row requests back to back are served by forwarding the written row.
// Reset clears the per-row valid bits at once; no clearing pass.
// A stalled rsp holds the output word and the request in flight; req.ready
// drops only while both are occupied.
// ----------------------------------------------------------------------------
module capability_bitmap_space (
	input  logic      clk,
	input  logic      arst_n,
	cbs_req_if.sink   req,
	cbs_rsp_if.source rsp
);
	import cbs_pkg::*;

	rd_req_t rd;
	wr_req_t wr;
	word_t   rdata;

	cbs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.rd     (rd),
		.wr     (wr),
		.rdata  (rdata)
	);

	cbs_bitmap_ram u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.rd     (rd),
		.wr     (wr),
		.rdata  (rdata)
	);

endmodule

// ----- src/cbs_checker.sv -----
// ----------------------------------------------------------------------------
// cbs_checker: port-level checks of the capability bitmap store
// Tracks words in flight and checks result field consistency.
// ----------------------------------------------------------------------------
module cbs_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [cbs_pkg::STAT_W-1:0] status,
	input logic                      present,
	input logic [cbs_pkg::IDX_W-1:0] mapped_phys,
	input logic [cbs_pkg::SIZE_W-1:0] mapped_size
);
	import cbs_pkg::*;

	logic [1:0] inflight_q;
	logic       in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 2'(in_acc) - 2'(out_acc);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(present)
			&& $stable(mapped_phys) && $stable(mapped_size))
		else $error("result word changed while stalled");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != 2'd0)
		else $error("result word without a request");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q != 2'd3)
		else $error("more words in flight than pipeline holds");

	a_insert_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> !present && mapped_size == '0
			&& mapped_phys == '0)
		else $error("insert status mixed with other result fields");

	a_phys_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mapped_phys != '0 |-> mapped_size == SIZE_W'(1))
		else $error("mapped index without a single-entry size");

endmodule

bind capability_bitmap_space cbs_checker u_cbs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (req.valid),
	.in_ready    (req.ready),
	.out_valid   (rsp.valid),
	.out_ready   (rsp.ready),
	.status      (rsp.status),
	.present     (rsp.present),
	.mapped_phys (rsp.mapped_phys),
	.mapped_size (rsp.mapped_size)
);

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: capability_bitmap_space request/result checker
// Replays a short table of directed requests (reset view, no-memory,
// whole-space grant, conflict, extreme indexes, unused action), then random
// requests clustered on a few bitmap rows so bits collide. A behavioral copy
// of the store predicts every result but those typed into the table; a stalling
// receiver and a bursty sender vary the handshake timing.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import cbs_pkg::*;

	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
	localparam int RANDOM_WORDS = 1400;
	localparam int PAUSE_AT     = 700;
	localparam int IDLE_LIMIT   = 3000;
	localparam int SETTLE       = 4;

	typedef struct {
		stat_t             status;
		logic              present;
		logic [IDX_W-1:0]  phys;
		logic [SIZE_W-1:0] size;
	} cap_result_t;

	typedef struct {
		logic [ACT_W-1:0] action;
		logic [IDX_W-1:0] index;
		logic             whole;
		logic             granted;
		logic             fixed;
		cap_result_t      known;
	} cap_row_t;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_SHUT} rx_mode_t;

	logic clk;
	logic arst_n;

	cbs_req_if req();
	cbs_rsp_if rsp();

	capability_bitmap_space uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	// shadow of the store
	word_t       shadow_rows [CB_WORDS];
	logic        bitmap_live;
	logic        space_granted;
	cap_result_t results_due [$];

	// typed-in expectation that travels with the request word
	logic        word_fixed;
	cap_result_t word_known;

	int       errors = 0;
	int       burst_left;
	int       idle_cycles = 0;
	rx_mode_t rx_mode = RX_OPEN;
	int       rx_left = 0;

	cap_row_t plan [25] = '{
		'{ACT_LOOKUP, 11'd0,    1'b0, 1'b0, 1'b1, '{ST_OK,       1'b0, 11'd0, 12'd2048}},
		'{ACT_DELETE, 11'd2047, 1'b0, 1'b1, 1'b1, '{ST_OK,       1'b0, 11'd0, 12'd0}},
		'{ACT_INSERT, 11'd5,    1'b0, 1'b0, 1'b1, '{ST_NO_MEM,   1'b0, 11'd0, 12'd0}},
		'{ACT_INSERT, 11'd2047, 1'b1, 1'b0, 1'b1, '{ST_NO_MEM,   1'b0, 11'd0, 12'd0}},
		'{ACT_UNUSED, 11'd2047, 1'b1, 1'b1, 1'b1, '{ST_OK,       1'b0, 11'd0, 12'd0}},
		'{ACT_INSERT, 11'd0,    1'b1, 1'b0, 1'b1, '{ST_OK,       1'b0, 11'd0, 12'd0}},
		'{ACT_INSERT, 11'd0,    1'b1, 1'b1, 1'b1, '{ST_PRESENT,  1'b0, 11'd0, 12'd0}},
		'{ACT_LOOKUP, 11'd2047, 1'b0, 1'b0, 1'b1, '{ST_OK,       1'b1, 11'd0, 12'd2048}},
		'{ACT_INSERT, 11'd1,    1'b1, 1'b1, 1'b0, '{ST_OK,       1'b0, 11'd0, 12'd0}},
		'{ACT_INSERT, 11'd0,    1'b1, 1'b0, 1'b1, '{ST_CONFLICT, 1'b0, 11'd0, 12'd0}},
		'{ACT_LOOKUP, 11'd1,    1'b0, 1'b0, 1'b1, '{ST_OK,       1'b1, 11'd1, 12'd1}},
		'{ACT_INSERT, 11'd0,    1'b0, 1'b0, 1'b0, '{ST_OK,       1'b0, 11'd0, 12'd0}},
		'{ACT_INSERT, 11'd2047, 1'b0, 1'b0, 1'b0, '{ST_OK,       1'b0, 11'd0, 12'd0}},
		'{ACT_INSERT, 11'd2047, 1'b0, 1'b1, 1'b0, '{ST_OK,       1'b0, 11'd0, 12'd0}},
		'{ACT_LOOKUP, 11'd2047, 1'b0, 1'b0, 1'b0, '{ST_OK,       1'b0, 11'd0, 12'd0}},
		'{ACT_DELETE, 11'd2047, 1'b0, 1'b0, 1'b0, '{ST_OK,       1'b0, 11'd0, 12'd0}},
		'{ACT_DELETE, 11'd2047, 1'b1, 1'b1, 1'b0, '{ST_OK,       1'b0, 11'd0, 12'd0}},
		'{ACT_LOOKUP, 11'd1024, 1'b0, 1'b0, 1'b0, '{ST_OK,       1'b0, 11'd0, 12'd0}},
		'{ACT_INSERT, 11'd31,   1'b0, 1'b0, 1'b0, '{ST_OK,       1'b0, 11'd0, 12'd0}},
		'{ACT_INSERT, 11'd32,   1'b0, 1'b1, 1'b0, '{ST_OK,       1'b0, 11'd0, 12'd0}},
		'{ACT_DELETE, 11'd31,   1'b0, 1'b0, 1'b0, '{ST_OK,       1'b0, 11'd0, 12'd0}},
		'{ACT_LOOKUP, 11'd32,   1'b0, 1'b0, 1'b0, '{ST_OK,       1'b0, 11'd0, 12'd0}},
		'{ACT_DELETE, 11'd1023, 1'b0, 1'b0, 1'b0, '{ST_OK,       1'b0, 11'd0, 12'd0}},
		'{ACT_UNUSED, 11'd0,    1'b0, 1'b0, 1'b1, '{ST_OK,       1'b0, 11'd0, 12'd0}},
		'{ACT_DELETE, 11'd0,    1'b0, 1'b0, 1'b0, '{ST_OK,       1'b0, 11'd0, 12'd0}}
	};

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Update the shadow store for one request and return the result it causes.
	function automatic cap_result_t apply_request(logic [ACT_W-1:0] act,
		logic [IDX_W-1:0] idx, logic whole, logic granted);
		cap_result_t      res;
		waddr_t           row;
		logic [BIT_W-1:0] col;
		logic             hit;
		res = '{ST_OK, 1'b0, '0, '0};
		row = waddr_t'(idx / WORD_BITS);
		col = BIT_W'(idx % WORD_BITS);
		hit = shadow_rows[row][col];
		unique case (act)
		ACT_INSERT: begin
			if (whole && idx == 0) begin
				if (bitmap_live)
					res.status = ST_CONFLICT;
				else if (space_granted)
					res.status = ST_PRESENT;
				else
					space_granted = 1'b1;
			end else if (!bitmap_live && !granted) begin
				res.status = ST_NO_MEM;
			end else begin
				// a fresh bitmap starts empty
				if (!bitmap_live) begin
					foreach (shadow_rows[i])
						shadow_rows[i] = '0;
					bitmap_live = 1'b1;
					hit = 1'b0;
				end
				res.status = hit ? ST_PRESENT : ST_OK;
				shadow_rows[row][col] = 1'b1;
			end
		end
		ACT_DELETE: begin
			if (bitmap_live) begin
				res.present = hit;
				shadow_rows[row][col] = 1'b0;
			end
		end
		ACT_LOOKUP: begin
			if (bitmap_live) begin
				res.phys    = idx;
				res.size    = SIZE_W'(1);
				res.present = space_granted | hit;
			end else begin
				res.size    = SIZE_W'(NUM_TASKS);
				res.present = space_granted;
			end
		end
		default: ;
		endcase
		return res;
	endfunction

	task automatic flag(string field, int want, int got);
		errors++;
		$display("%0t: %s expected %0d actual %0d", $time, field, want, got);
	endtask

	// Hold the word until the edge that takes it.
	task automatic send_word(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx,
		logic whole, logic granted, logic fixed, cap_result_t known);
		req.valid         <= 1'b1;
		req.action        <= act;
		req.cap_index     <= idx;
		req.full_space    <= whole;
		req.store_granted <= granted;
		word_fixed        <= fixed;
		word_known        <= known;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
	endtask

	// Advance the burst; at its end drop valid for a random gap.
	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
				: $urandom_range(0, 30);
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 12))
				@(posedge clk);
		end
	endtask

	// Drop valid and hold until every result is back.
	task automatic drain();
		req.valid <= 1'b0;
		@(negedge clk);
		while (results_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		cap_result_t seen;
		cap_result_t want;
		cap_result_t guess;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				seen = '{stat_t'(rsp.status), rsp.present, rsp.mapped_phys,
					rsp.mapped_size};
				if (results_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected word status %0d present %0d phys %0d size %0d",
						$time, seen.status, seen.present, seen.phys, seen.size);
				end else begin
					want = results_due.pop_front();
					if (seen.status !== want.status)
						flag("status", want.status, seen.status);
					if (seen.present !== want.present)
						flag("present", want.present, seen.present);
					if (seen.phys !== want.phys)
						flag("mapped_phys", want.phys, seen.phys);
					if (seen.size !== want.size)
						flag("mapped_size", want.size, seen.size);
				end
			end
			if (req.valid && req.ready) begin
				guess = apply_request(req.action, req.cap_index, req.full_space,
					req.store_granted);
				results_due.push_back(word_fixed ? word_known : guess);
			end
		end
	end

	// receiver: stretches of open, coin-flip, sparse and shut ready
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_left <= $urandom_range(16, 160);
		end else begin
			rx_left <= rx_left - 1;
		end
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			unique case (rx_mode)
			RX_OPEN:   rsp.ready <= 1'b1;
			RX_COIN:   rsp.ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: rsp.ready <= ($urandom_range(0, 3) == 0);
			default:   rsp.ready <= 1'b0;
			endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [ACT_W-1:0] act;
		logic [IDX_W-1:0] idx;
		int               pick;
		cap_result_t      none;
		none = '{ST_OK, 1'b0, '0, '0};
		foreach (shadow_rows[i])
			shadow_rows[i] = '0;
		bitmap_live   = 1'b0;
		space_granted = 1'b0;
		burst_left    = 0;
		arst_n            <= 1'b0;
		req.valid         <= 1'b0;
		req.action        <= ACT_INSERT;
		req.cap_index     <= '0;
		req.full_space    <= 1'b0;
		req.store_granted <= 1'b0;
		word_fixed        <= 1'b0;
		word_known        <= none;
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			send_word(plan[i].action, plan[i].index, plan[i].whole, plan[i].granted,
				plan[i].fixed, plan[i].known);
			pace();
		end
		drain();

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				act = ACT_INSERT;
			else if (pick < 68)
				act = ACT_DELETE;
			else if (pick < 97)
				act = ACT_LOOKUP;
			else
				act = ACT_UNUSED;
			// mostly the first three rows, so inserts and deletes hit set bits
			pick = $urandom_range(0, 9);
			if (pick < 6)
				idx = IDX_W'($urandom_range(0, 95));
			else if (pick == 6)
				idx = '0;
			else
				idx = IDX_W'($urandom());
			send_word(act, idx, $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)),
				1'b0, none);
			if (n == PAUSE_AT)
				drain();
			else
				pace();
		end
		drain();

		if (errors == 0 && results_due.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
